/* rtl/core/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared codes and widths of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int ADDR_W  = 32;
  localparam int LOG_W   = 5;
  localparam int CLS_W   = 5;
  localparam int SZ_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LOG2 = 1'b1;

  localparam logic [1:0] ACT_INIT    = 2'd0;
  localparam logic [1:0] ACT_ALLOC   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_UNINIT        = 4'd1;
  localparam logic [3:0] ST_ZERO_SIZE     = 4'd2;
  localparam logic [3:0] ST_NO_SPACE      = 4'd3;
  localparam logic [3:0] ST_ALREADY_ALLOC = 4'd4;
  localparam logic [3:0] ST_ILLEGAL_PTR   = 4'd5;
  localparam logic [3:0] ST_NOT_ALLOC     = 4'd6;
  localparam logic [3:0] ST_MISALIGN_BLK  = 4'd7;
  localparam logic [3:0] ST_MISALIGN_HEAP = 4'd8;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CLR    = 10'b0000000010,
    S_IPUSH  = 10'b0000000100,
    S_ASCAN  = 10'b0000001000,
    S_ACHK   = 10'b0000010000,
    S_ASPLIT = 10'b0000100000,
    S_RCHK   = 10'b0001000000,
    S_MSTART = 10'b0010000000,
    S_MWALK  = 10'b0100000000,
    S_RPUSH  = 10'b1000000000
  } state_e;

endpackage

/* rtl/core/bba_ceil_log2.sv */
// ----------------------------------------------------------------------------
// bba_ceil_log2
// Size class of a request: ceil(log2(size)), at least one unit.
// ----------------------------------------------------------------------------
module bba_ceil_log2 import bba_pkg::*; #(
  parameter int MIN_BLOCK_LOG2 = 6
) (
  input  logic [ADDR_W-1:0] size_i,
  output logic [SZ_W-1:0]   class_o
);

  logic [ADDR_W-1:0] sm1;
  logic [SZ_W-1:0]   msb;

  always_comb begin
    sm1 = size_i - ADDR_W'(1);
    msb = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      if (sm1[i]) msb = SZ_W'(i + 1);
    end
    if (size_i <= ADDR_W'(1)) msb = '0;
    class_o = (msb < SZ_W'(MIN_BLOCK_LOG2)) ? SZ_W'(MIN_BLOCK_LOG2) : msb;
  end

endmodule

/* rtl/core/buddy_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Power-of-two buddy allocator; free lists and block classes in on-chip RAM.
// ----------------------------------------------------------------------------
// Init sweeps the class RAM, then pushes the initial free blocks; alloc scans the
//   classes for a free block, checks it and splits it down; release checks the block,
//   then per merge level walks the free list for the buddy before pushing the result.
// Errors found at accept return in the next cycle. One item at a time (busy high); the
//   next item is accepted in the done_o cycle. The receiver cannot stall results.
// Reset empties lists and clears ready; class RAM is swept by every init with an aligned heap base.
module buddy_block_allocator_unit import bba_pkg::*; #(
  parameter int MAX_HEAP_LOG2  = 16,
  parameter int MIN_BLOCK_LOG2 = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action_i,
  input  logic [ADDR_W-1:0]    request_bytes_i,
  input  logic [ADDR_W-1:0]    release_address_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  output logic                 done_o,
  output logic [ADDR_W-1:0]    block_address_o,
  output logic [3:0]           status_o
);

  localparam int UNIT_BITS = MAX_HEAP_LOG2 - MIN_BLOCK_LOG2;
  localparam int UNITS     = 1 << UNIT_BITS;
  localparam int NCLS      = MAX_HEAP_LOG2;
  localparam int CIDX_W    = $clog2(NCLS);
  localparam logic [LOG_W-1:0] MINL = LOG_W'(MIN_BLOCK_LOG2);
  localparam logic [LOG_W-1:0] MAXL = LOG_W'(MAX_HEAP_LOG2);

  state_e state_q, state_d;
  logic ready_q, ready_d;
  logic [ADDR_W-1:0] base_cfg_q;
  logic [LOG_W-1:0]  log2_cfg_q;
  logic [ADDR_W-1:0] live_base_q, live_base_d;
  logic [LOG_W-1:0]  live_log2_q, live_log2_d;
  logic done_q, done_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [3:0]        status_q, status_d;

  logic [SZ_W-1:0]      r_q, r_d, s_q, s_d;
  logic [UNIT_BITS-1:0] u_q, u_d, cur_q, cur_d, prev_q, prev_d, cnt_q, cnt_d;
  logic [LOG_W-1:0]     k_q, k_d, tbl_q, tbl_d;
  logic [ADDR_W-1:0]    off_q, off_d;
  logic                 at_head_q, at_head_d;

  logic                 head_vld_q [NCLS];
  logic [UNIT_BITS-1:0] head_idx_q [NCLS];
  logic                 hclr, hwe, hwv;
  logic [CIDX_W-1:0]    hwi;
  logic [UNIT_BITS-1:0] hwd;

  logic [UNIT_BITS:0]   link_mem [UNITS];
  logic [CLS_W-1:0]     cls_mem  [UNITS];
  logic [UNIT_BITS:0]   lrd_q, lwdata;
  logic [UNIT_BITS-1:0] lraddr, lwaddr, craddr, cwaddr;
  logic                 lwe, cwe;
  logic [CLS_W-1:0]     crd_q, cwdata;

  logic [SZ_W-1:0]      rc;
  logic [LOG_W-1:0]     h_cl, tbl_c, kn;
  logic [ADDR_W-1:0]    hmask, rel_off;
  logic [UNIT_BITS-1:0] rel_u, bitm, buddy, pu;
  logic [CIDX_W-1:0]    si, ki;
  logic [SZ_W-1:0]      sn;

  bba_ceil_log2 #(.MIN_BLOCK_LOG2(MIN_BLOCK_LOG2)) u_ceil (
    .size_i  (request_bytes_i),
    .class_o (rc)
  );

  always_comb begin
    h_cl = (log2_cfg_q < MINL) ? MINL : ((log2_cfg_q > MAXL) ? MAXL : log2_cfg_q);
    tbl_c = h_cl - MINL;
    if (tbl_c < MINL) tbl_c = MINL;
    hmask   = (ADDR_W'(1) << h_cl) - ADDR_W'(1);
    rel_off = release_address_i - live_base_q;
    rel_u   = rel_off[MIN_BLOCK_LOG2 +: UNIT_BITS];
    si      = s_q[CIDX_W-1:0];
    ki      = k_q[CIDX_W-1:0];
    bitm    = UNIT_BITS'(1) << (k_q - MINL);
    buddy   = u_q ^ bitm;
    kn      = k_q - LOG_W'(1);
    sn      = s_q - SZ_W'(1);
    pu      = u_q + (UNIT_BITS'(1) << (sn - SZ_W'(MIN_BLOCK_LOG2)));
  end

  always_comb begin
    state_d = state_q;  ready_d = ready_q;
    live_base_d = live_base_q;  live_log2_d = live_log2_q;
    done_d = 1'b0;  addr_d = addr_q;  status_d = status_q;
    r_d = r_q;  s_d = s_q;  u_d = u_q;  cur_d = cur_q;  prev_d = prev_q;
    cnt_d = cnt_q;  k_d = k_q;  tbl_d = tbl_q;  off_d = off_q;  at_head_d = at_head_q;
    hclr = 1'b0;  hwe = 1'b0;  hwv = 1'b0;  hwi = '0;  hwd = '0;
    lraddr = '0;  lwe = 1'b0;  lwaddr = '0;  lwdata = '0;
    craddr = '0;  cwe = 1'b0;  cwaddr = '0;  cwdata = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          addr_d   = '0;
          status_d = ST_OK;
          unique case (action_i)
            ACT_INIT: begin
              if ((base_cfg_q & hmask) != '0) begin
                done_d = 1'b1;  status_d = ST_MISALIGN_HEAP;
              end else begin
                hclr = 1'b1;
                live_base_d = base_cfg_q;  live_log2_d = h_cl;
                tbl_d = tbl_c;  k_d = h_cl;  u_d = '0;  cnt_d = '0;
                state_d = S_CLR;
              end
            end
            ACT_ALLOC: begin
              if (!ready_q) begin
                done_d = 1'b1;  status_d = ST_UNINIT;
              end else if (request_bytes_i == '0) begin
                done_d = 1'b1;  status_d = ST_ZERO_SIZE;
              end else begin
                r_d = rc;  s_d = rc;  state_d = S_ASCAN;
              end
            end
            ACT_RELEASE: begin
              if (!ready_q) begin
                done_d = 1'b1;  status_d = ST_UNINIT;
              end else if ((rel_off >> live_log2_q) != '0) begin
                done_d = 1'b1;  status_d = ST_ILLEGAL_PTR;
              end else begin
                off_d = rel_off;  u_d = rel_u;  craddr = rel_u;  state_d = S_RCHK;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_CLR: begin
        cwe = 1'b1;  cwaddr = cnt_q;  cwdata = '0;
        cnt_d = cnt_q + UNIT_BITS'(1);
        if (&cnt_q) state_d = S_IPUSH;
      end
      S_IPUSH: begin
        if (k_q > tbl_q) begin
          lwe = 1'b1;  lwaddr = u_q;
          lwdata = {head_vld_q[kn[CIDX_W-1:0]], head_idx_q[kn[CIDX_W-1:0]]};
          hwe = 1'b1;  hwi = kn[CIDX_W-1:0];  hwv = 1'b1;  hwd = u_q;
          u_d = u_q + (UNIT_BITS'(1) << (kn - MINL));
          k_d = kn;
        end else begin
          ready_d = 1'b1;  done_d = 1'b1;  state_d = S_IDLE;
        end
      end
      S_ASCAN: begin
        if (s_q >= SZ_W'(live_log2_q)) begin
          done_d = 1'b1;  status_d = ST_NO_SPACE;  state_d = S_IDLE;
        end else if (head_vld_q[si]) begin
          u_d = head_idx_q[si];  craddr = head_idx_q[si];  lraddr = head_idx_q[si];
          state_d = S_ACHK;
        end else begin
          s_d = s_q + SZ_W'(1);
        end
      end
      S_ACHK: begin
        if (crd_q != '0) begin
          done_d = 1'b1;  status_d = ST_ALREADY_ALLOC;  state_d = S_IDLE;
        end else begin
          hwe = 1'b1;  hwi = si;  hwv = lrd_q[UNIT_BITS];  hwd = lrd_q[UNIT_BITS-1:0];
          cwe = 1'b1;  cwaddr = u_q;  cwdata = CLS_W'(r_q);
          state_d = S_ASPLIT;
        end
      end
      S_ASPLIT: begin
        if (s_q > r_q) begin
          lwe = 1'b1;  lwaddr = pu;
          lwdata = {head_vld_q[sn[CIDX_W-1:0]], head_idx_q[sn[CIDX_W-1:0]]};
          hwe = 1'b1;  hwi = sn[CIDX_W-1:0];  hwv = 1'b1;  hwd = pu;
          s_d = sn;
        end else begin
          done_d = 1'b1;
          addr_d = live_base_q + (ADDR_W'(u_q) << MIN_BLOCK_LOG2);
          state_d = S_IDLE;
        end
      end
      S_RCHK: begin
        if (crd_q < CLS_W'(MIN_BLOCK_LOG2) || crd_q >= CLS_W'(live_log2_q)) begin
          done_d = 1'b1;  status_d = ST_NOT_ALLOC;  state_d = S_IDLE;
        end else if ((off_q & ((ADDR_W'(1) << crd_q) - ADDR_W'(1))) != '0) begin
          done_d = 1'b1;  status_d = ST_MISALIGN_BLK;  state_d = S_IDLE;
        end else begin
          cwe = 1'b1;  cwaddr = u_q;  cwdata = '0;
          k_d = LOG_W'(crd_q);
          state_d = S_MSTART;
        end
      end
      S_MSTART: begin
        if ((SZ_W'(k_q) + SZ_W'(1) < SZ_W'(live_log2_q)) && head_vld_q[ki]) begin
          cur_d = head_idx_q[ki];  lraddr = head_idx_q[ki];  at_head_d = 1'b1;
          state_d = S_MWALK;
        end else begin
          state_d = S_RPUSH;
        end
      end
      S_MWALK: begin
        if (cur_q == buddy) begin
          if (at_head_q) begin
            hwe = 1'b1;  hwi = ki;  hwv = lrd_q[UNIT_BITS];  hwd = lrd_q[UNIT_BITS-1:0];
          end else begin
            lwe = 1'b1;  lwaddr = prev_q;  lwdata = lrd_q;
          end
          u_d = u_q & ~bitm;
          k_d = k_q + LOG_W'(1);
          state_d = S_MSTART;
        end else begin
          prev_d = cur_q;  at_head_d = 1'b0;
          if (lrd_q[UNIT_BITS]) begin
            cur_d = lrd_q[UNIT_BITS-1:0];  lraddr = lrd_q[UNIT_BITS-1:0];
          end else begin
            state_d = S_RPUSH;
          end
        end
      end
      S_RPUSH: begin
        lwe = 1'b1;  lwaddr = u_q;  lwdata = {head_vld_q[ki], head_idx_q[ki]};
        hwe = 1'b1;  hwi = ki;  hwv = 1'b1;  hwd = u_q;
        done_d = 1'b1;  state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b0;
      base_cfg_q  <= '0;
      log2_cfg_q  <= LOG_W'(16);
      live_base_q <= '0;
      live_log2_q <= '0;
      done_q      <= 1'b0;
      for (int i = 0; i < NCLS; i++) head_vld_q[i] <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      live_base_q <= live_base_d;
      live_log2_q <= live_log2_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAP_BASE) base_cfg_q <= cfg_wdata_i;
        else if (cfg_idx_i == CFG_HEAP_LOG2) log2_cfg_q <= cfg_wdata_i[LOG_W-1:0];
      end
      if (hclr) begin
        for (int i = 0; i < NCLS; i++) head_vld_q[i] <= 1'b0;
      end else if (hwe) begin
        head_vld_q[hwi] <= hwv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hwe) head_idx_q[hwi] <= hwd;
    addr_q <= addr_d;  status_q <= status_d;
    r_q <= r_d;  s_q <= s_d;  u_q <= u_d;  cur_q <= cur_d;  prev_q <= prev_d;
    cnt_q <= cnt_d;  k_q <= k_d;  tbl_q <= tbl_d;  off_q <= off_d;
    at_head_q <= at_head_d;
  end

  always_ff @(posedge clk_i) begin
    if (lwe) link_mem[lwaddr] <= lwdata;
    lrd_q <= link_mem[lraddr];
    if (cwe) cls_mem[cwaddr] <= cwdata;
    crd_q <= cls_mem[craddr];
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign block_address_o = addr_q;
  assign status_o        = status_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("busy dropped without a result");

  a_err_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (block_address_o == '0))
    else $error("error result carries an address");

  a_start_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("accepted item lost");

  a_clr_no_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !hwe) else $error("list head written during sweep");

endmodule

/* test/tb_buddy_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_unit
// Self-checking bench for the buddy allocator: directed table, then random
// init/alloc/release and illegal-action traffic over several heap settings,
// all checked against an in-bench model of the free lists and block classes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_buddy_block_allocator_unit;
  import bba_pkg::*;

  localparam int MAXH  = 16;
  localparam int MINB  = 6;
  localparam int UBITS = MAXH - MINB;
  localparam int NU    = 1 << UBITS;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [3:0]        status;
  } alloc_res_t;

  typedef struct {
    logic [1:0]        act;
    logic [ADDR_W-1:0] req;
    logic [ADDR_W-1:0] rel;
    bit                fixed;
    alloc_res_t        res;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        action_i = ACT_INIT;
  logic [ADDR_W-1:0] request_bytes_i = '0;
  logic [ADDR_W-1:0] release_address_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_HEAP_BASE;
  logic [ADDR_W-1:0] cfg_wdata_i = '0;
  logic              done_o;
  logic [ADDR_W-1:0] block_address_o;
  logic [3:0]        status_o;

  buddy_block_allocator_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // allocator shadow
  logic [UBITS:0]    heads [MAXH];
  logic [UBITS:0]    links [NU];
  logic [CLS_W-1:0]  cls   [NU];
  logic [ADDR_W-1:0] reg_base, live_base;
  logic [LOG_W-1:0]  reg_log2;
  int unsigned       live_log2;
  bit                ready;

  alloc_res_t        pending_q [$];
  logic [ADDR_W-1:0] live_q [$];
  int                errors = 0;
  int                idle_pct = 0;

  task automatic mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void push_blk(int unsigned k, int unsigned u);
    u = u & (NU - 1);
    if (k >= MAXH) return;
    links[u] = heads[k];
    heads[k] = {1'b1, u[UBITS-1:0]};
  endfunction

  function automatic bit unlink_blk(int unsigned k, int unsigned u);
    logic [UBITS:0] cur;
    int unsigned prev, idx;
    bit at_head;
    prev = 0;
    at_head = 1;
    if (k >= MAXH) return 0;
    cur = heads[k];
    for (int n = 0; n < NU && cur[UBITS]; n++) begin
      idx = cur[UBITS-1:0];
      if (idx == u) begin
        if (at_head) heads[k] = links[idx];
        else links[prev] = links[idx];
        return 1;
      end
      prev = idx;
      at_head = 0;
      cur = links[idx];
    end
    return 0;
  endfunction

  function automatic alloc_res_t predict(logic [1:0] act, logic [ADDR_W-1:0] req,
                                         logic [ADDR_W-1:0] rel);
    alloc_res_t  o;
    int unsigned h, tbl, off, r, s, u, k, bitv;
    logic [ADDR_W-1:0] ofs;
    o = '{addr: '0, status: ST_OK};
    case (act)
      ACT_INIT: begin
        h = reg_log2;
        if (h < MINB) h = MINB;
        if (h > MAXH) h = MAXH;
        if ((reg_base & ((64'd1 << h) - 1)) != 0) o.status = ST_MISALIGN_HEAP;
        else begin
          foreach (heads[i]) heads[i] = '0;
          foreach (cls[i]) cls[i] = '0;
          tbl = h - MINB;
          if (tbl < MINB) tbl = MINB;
          off = 0;
          for (k = h; k > tbl; k--) begin
            push_blk(k - 1, off);
            off += 1 << (k - 1 - MINB);
          end
          live_base = reg_base;
          live_log2 = h;
          ready = 1;
        end
      end
      ACT_ALLOC: begin
        if (!ready) o.status = ST_UNINIT;
        else if (req == 0) o.status = ST_ZERO_SIZE;
        else begin
          r = 0;
          while ((64'd1 << r) < {32'd0, req}) r++;
          if (r < MINB) r = MINB;
          s = r;
          while (s < live_log2 && s < MAXH && !heads[s][UBITS]) s++;
          if (s >= live_log2 || s >= MAXH) o.status = ST_NO_SPACE;
          else begin
            u = heads[s][UBITS-1:0];
            if (cls[u] != 0) o.status = ST_ALREADY_ALLOC;
            else begin
              heads[s] = links[u];
              while (s > r) begin
                s--;
                push_blk(s, u + (1 << (s - MINB)));
              end
              cls[u] = CLS_W'(r);
              o.addr = live_base + (u << MINB);
            end
          end
        end
      end
      ACT_RELEASE: begin
        if (!ready) o.status = ST_UNINIT;
        else begin
          ofs = rel - live_base;
          if ({32'd0, ofs} >= (64'd1 << live_log2)) o.status = ST_ILLEGAL_PTR;
          else begin
            u = (ofs >> MINB) & (NU - 1);
            k = cls[u];
            if (k < MINB || k >= live_log2) o.status = ST_NOT_ALLOC;
            else if ((ofs & ((1 << k) - 1)) != 0) o.status = ST_MISALIGN_BLK;
            else begin
              cls[u] = '0;
              while (k + 1 < live_log2) begin
                bitv = 1 << (k - MINB);
                if (!unlink_blk(k, u ^ bitv)) break;
                u = u & ~bitv;
                k++;
              end
              push_blk(k, u);
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) mismatch("result with nothing pending");
      else begin
        if (block_address_o !== pending_q[0].addr)
          mismatch($sformatf("block_address %h, want %h", block_address_o,
                             pending_q[0].addr));
        if (status_o !== pending_q[0].status)
          mismatch($sformatf("status %0d, want %0d", status_o, pending_q[0].status));
        void'(pending_q.pop_front());
      end
    end
  end

  // returns the predicted result of the accepted item
  task automatic issue(input logic [1:0] act, input logic [ADDR_W-1:0] req,
                       input logic [ADDR_W-1:0] rel, output alloc_res_t p);
    bit taken;
    taken = 0;
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start = 1'b1;
    action_i = act;
    request_bytes_i = req;
    release_address_i = rel;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy) begin
        taken = 1;
        p = predict(act, req, rel);
        pending_q.push_back(p);
        if (act == ACT_ALLOC && p.status == ST_OK) live_q.push_back(p.addr);
        if (act == ACT_INIT && p.status == ST_OK) live_q.delete();
      end
      @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_q.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] v);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_HEAP_BASE) reg_base = v;
    else reg_log2 = v[LOG_W-1:0];
  endtask

  task automatic run_table(input row_t rows[$]);
    alloc_res_t p;
    foreach (rows[i]) begin
      issue(rows[i].act, rows[i].req, rows[i].rel, p);
      if (rows[i].fixed && p !== rows[i].res)
        mismatch($sformatf("row %0d predictor disagrees with table", i));
    end
  endtask

  task automatic random_phase(input int n);
    alloc_res_t p;
    int unsigned sel, j, hb;
    logic [ADDR_W-1:0] req, rel;
    logic [1:0] act;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      req = $urandom();
      rel = $urandom();
      hb = (live_log2 > 0) ? live_log2 : MAXH;
      if (sel < 48) begin
        act = ACT_ALLOC;
        if ($urandom_range(9) != 0) req = $urandom_range(1, 1 << $urandom_range(0, hb - 1));
      end else if (sel < 84 && live_q.size() != 0) begin
        act = ACT_RELEASE;
        j = $urandom_range(live_q.size() - 1);
        rel = live_q[j];
        live_q.delete(j);
      end else if (sel < 94) begin
        act = ACT_RELEASE;
        if (sel < 90) rel = live_base + $urandom_range(0, (1 << hb) - 1);
      end else if (sel < 97) act = 2'd3;
      else act = ACT_INIT;
      issue(act, req, rel, p);
    end
  endtask

  initial begin
    row_t pre[$], post[$];
    logic [LOG_W-1:0] sizes[8] = '{5'd7, 5'd8, 5'd9, 5'd31, 5'd10, 5'd0, 5'd16, 5'd11};
    foreach (heads[i]) heads[i] = '0;
    foreach (links[i]) links[i] = '0;
    foreach (cls[i]) cls[i] = '0;
    reg_base = '0;
    reg_log2 = 5'd16;
    live_base = '0;
    live_log2 = 0;
    ready = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    pre = '{
      '{ACT_ALLOC, 32'd64, 0, 1, '{0, ST_UNINIT}},
      '{ACT_RELEASE, 0, 32'd0, 1, '{0, ST_UNINIT}},
      '{2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{0, ST_OK}},
      '{ACT_INIT, 0, 0, 1, '{0, ST_OK}},
      '{ACT_ALLOC, 32'd0, 0, 1, '{0, ST_ZERO_SIZE}},
      '{ACT_ALLOC, 32'hFFFF_FFFF, 0, 1, '{0, ST_NO_SPACE}},
      '{ACT_ALLOC, 32'd32769, 0, 1, '{0, ST_NO_SPACE}},
      '{ACT_ALLOC, 32'd32768, 0, 1, '{32'd0, ST_OK}},
      '{ACT_ALLOC, 32'd1, 0, 0, '{0, 0}},
      '{ACT_ALLOC, 32'd100, 0, 0, '{0, 0}},
      '{ACT_RELEASE, 0, 32'hFFFF_FFFF, 1, '{0, ST_ILLEGAL_PTR}},
      '{ACT_RELEASE, 0, 32'd65472, 1, '{0, ST_NOT_ALLOC}},
      '{ACT_RELEASE, 0, 32'd32, 1, '{0, ST_MISALIGN_BLK}},
      '{ACT_RELEASE, 0, 32'd0, 1, '{0, ST_OK}},
      '{ACT_RELEASE, 0, 32'd0, 1, '{0, ST_NOT_ALLOC}},
      '{ACT_ALLOC, 32'd64, 0, 0, '{0, 0}},
      '{ACT_INIT, 0, 0, 1, '{0, ST_OK}}
    };
    idle_pct = 12;
    run_table(pre);
    drain();
    cfg_write(CFG_HEAP_BASE, 32'hFFFF_FFFF);
    cfg_write(CFG_HEAP_LOG2, 32'h0000_001F);
    post = '{
      '{ACT_ALLOC, 32'd64, 0, 0, '{0, 0}},
      '{ACT_INIT, 0, 0, 1, '{0, ST_MISALIGN_HEAP}},
      '{ACT_ALLOC, 32'd64, 0, 0, '{0, 0}}
    };
    run_table(post);
    drain();
    cfg_write(CFG_HEAP_BASE, 32'hFFFF_FFC0);
    cfg_write(CFG_HEAP_LOG2, 32'd0);
    post = '{
      '{ACT_INIT, 0, 0, 1, '{0, ST_OK}},
      '{ACT_ALLOC, 32'd1, 0, 1, '{0, ST_NO_SPACE}},
      '{ACT_RELEASE, 0, 32'hFFFF_FFC0, 1, '{0, ST_NOT_ALLOC}}
    };
    run_table(post);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph < 3) ? 12 : (ph < 6) ? 60 : 0;
      cfg_write(CFG_HEAP_BASE, (ph == 3) ? 32'h0000_0040 :
                {16'($urandom_range(0, 65535)), 16'h0000});
      cfg_write(CFG_HEAP_LOG2, {27'd0, sizes[ph]});
      begin
        alloc_res_t p;
        issue(ACT_INIT, 0, 0, p);
      end
      random_phase(240);
      drain();
    end

    if (errors == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(64'd200_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
